@@ hdl/ccfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar field editor package
// Operation codes, field limits and the month length function shared by the
// time-setting editor.
// ----------------------------------------------------------------------------
package ccfe_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_MODE   = 3'd1,
    OP_SELECT = 3'd2,
    OP_UP     = 3'd3,
    OP_DOWN   = 3'd4,
    OP_LOAD   = 3'd5
  } op_t;

  localparam int unsigned FIELD_COUNT = 6;
  localparam logic [2:0]  LAST_FIELD  = 3'd5;

  localparam logic [7:0]  YEAR_MAX    = 8'd99;
  localparam logic [7:0]  MONTH_MAX   = 8'd12;
  localparam logic [7:0]  HOUR_MAX    = 8'd23;
  localparam logic [7:0]  MINSEC_MAX  = 8'd59;

  localparam logic [15:0] BLINK_RESET = 16'd500;

  // Length of a month; zero for a month code outside one to twelve, which
  // leaves the day unwrapped. Leap years are those whose low two bits are zero.
  function automatic logic [4:0] day_limit(input logic [7:0] month,
                                           input logic [1:0] year_low);
    logic [4:0] lim;
    case (month) inside
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: lim = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    lim = 5'd30;
      8'd2:                                       lim = (year_low == 2'd0) ? 5'd29 : 5'd28;
      default:                                    lim = 5'd0;
    endcase
    return lim;
  endfunction

endpackage

@@ hdl/clock_calendar_field_editor.sv @@
// ----------------------------------------------------------------------------
// Calendar clock field editor
// Time-setting editor for a real-time clock: six date and time fields, an
// edit mode with a selected field, up and down stepping with calendar wrap,
// and a blink flag driven by timer ticks.
// ----------------------------------------------------------------------------
// Usage. Each input word carries an operation (tick, mode key, select key,
// up key, down key or load time) together with the clock's current time,
// which only the load operation uses. Every accepted word produces exactly
// one result word on the output channel: the six fields after the operation,
// the edit flag, the selected field, the blanking flag for the display and a
// commit strobe that is set on the mode key that leaves edit mode.
// Both channels use a valid/ready handshake. A word is captured in an input
// register at the edge at which it is accepted; once the output register is
// free, the editor state is updated and the result word is loaded into the
// output register, from which the receiver takes it. One word is taken per
// cycle for as long as results are taken: throughput is one word per clock,
// set by the single pass of next-state logic between the two registers.
// When the receiver stalls, the result stays in the output register and the
// input register holds the next word; input ready falls only once both are
// full, so no word is lost or repeated.
// Reset (synchronous, active high) clears all fields, leaves edit mode,
// selects the year, clears the blink flag and tick count, empties both
// registers and sets the blink period register to 500 ticks. The blink
// period is written through the APB port at any of its four addresses.
// ----------------------------------------------------------------------------
module clock_calendar_field_editor (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [6:0]  load_year,
  input  logic [3:0]  load_month,
  input  logic [4:0]  load_day,
  input  logic [4:0]  load_hour,
  input  logic [5:0]  load_minute,
  input  logic [5:0]  load_second,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        editing,
  output logic [2:0]  selected,
  output logic        blank_selected,
  output logic        commit,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration register. There is a single register, so every address in
  // the two-bit space decodes to it.
  // --------------------------------------------------------------------------
  logic [15:0] blink_period;

  assign pready = 1'b1;
  assign prdata = {16'd0, blink_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= ccfe_pkg::BLINK_RESET;
    end else if (psel && penable && pwrite && (paddr <= 2'd3)) begin
      blink_period <= pwdata[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Input register and handshake. The input stage advances whenever the
  // output register is empty or being emptied in the same cycle.
  // --------------------------------------------------------------------------
  logic        s1_valid;
  logic [2:0]  op_q;
  logic [6:0]  ld_year_q;
  logic [3:0]  ld_month_q;
  logic [4:0]  ld_day_q;
  logic [4:0]  ld_hour_q;
  logic [5:0]  ld_minute_q;
  logic [5:0]  ld_second_q;
  logic        advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q        <= operation;
      ld_year_q   <= load_year;
      ld_month_q  <= load_month;
      ld_day_q    <= load_day;
      ld_hour_q   <= load_hour;
      ld_minute_q <= load_minute;
      ld_second_q <= load_second;
    end
  end

  // --------------------------------------------------------------------------
  // Editor state.
  // --------------------------------------------------------------------------
  logic [6:0]  fields [ccfe_pkg::FIELD_COUNT];
  logic        edit_mode;
  logic [2:0]  field_index;
  logic        blink_flag;
  logic [15:0] tick_count;

  logic [6:0]  fields_next [ccfe_pkg::FIELD_COUNT];
  logic        edit_mode_next;
  logic [2:0]  field_index_next;
  logic        blink_flag_next;
  logic [15:0] tick_count_next;
  logic        commit_next;

  // Up step: each field plus one where selected, one bit wider so that a
  // field at 127 can exceed its limit before wrapping.
  logic [7:0]  up_v [ccfe_pkg::FIELD_COUNT];
  // Down step: each field minus one where selected, with a flag for a step
  // below zero.
  logic [6:0]  dn_v  [ccfe_pkg::FIELD_COUNT];
  logic        dn_uf [ccfe_pkg::FIELD_COUNT];

  logic [7:0]  u_year, u_month, u_day, u_hour, u_minute, u_second;
  logic [6:0]  d_year, d_month, d_day, d_hour, d_minute, d_second;
  logic [4:0]  lim_up, lim_dn;
  logic [16:0] tick_sum;

  always_comb begin
    for (int i = 0; i < ccfe_pkg::FIELD_COUNT; i++) begin
      up_v[i]  = {1'b0, fields[i]} + {7'd0, (field_index == 3'(i))};
      dn_v[i]  = fields[i] - {6'd0, (field_index == 3'(i))};
      dn_uf[i] = (field_index == 3'(i)) && (fields[i] == 7'd0);
    end

    // Up wrap: every field above a defined maximum restarts at its minimum.
    u_year   = (up_v[0] > ccfe_pkg::YEAR_MAX)   ? 8'd0 : up_v[0];
    u_month  = (up_v[1] > ccfe_pkg::MONTH_MAX)  ? 8'd1 : up_v[1];
    lim_up   = ccfe_pkg::day_limit(u_month, u_year[1:0]);
    u_day    = ((lim_up != 5'd0) && (up_v[2] > {3'd0, lim_up})) ? 8'd1 : up_v[2];
    u_hour   = (up_v[3] > ccfe_pkg::HOUR_MAX)   ? 8'd0 : up_v[3];
    u_minute = (up_v[4] > ccfe_pkg::MINSEC_MAX) ? 8'd0 : up_v[4];
    u_second = (up_v[5] > ccfe_pkg::MINSEC_MAX) ? 8'd0 : up_v[5];

    // Down wrap: a step below the minimum lands on the maximum. A month of
    // zero is treated as below the minimum even when not the stepped field.
    d_year   = dn_uf[0] ? ccfe_pkg::YEAR_MAX[6:0] : dn_v[0];
    d_month  = (dn_uf[1] || (dn_v[1] == 7'd0)) ? ccfe_pkg::MONTH_MAX[6:0] : dn_v[1];
    lim_dn   = ccfe_pkg::day_limit({1'b0, d_month}, d_year[1:0]);
    if (lim_dn == 5'd0) begin
      d_day = dn_v[2];
    end else if (dn_uf[2] || (dn_v[2] == 7'd0)) begin
      d_day = {2'd0, lim_dn};
    end else if (dn_v[2] > {2'd0, lim_dn}) begin
      d_day = 7'd1;
    end else begin
      d_day = dn_v[2];
    end
    d_hour   = dn_uf[3] ? ccfe_pkg::HOUR_MAX[6:0]   : dn_v[3];
    d_minute = dn_uf[4] ? ccfe_pkg::MINSEC_MAX[6:0] : dn_v[4];
    d_second = dn_uf[5] ? ccfe_pkg::MINSEC_MAX[6:0] : dn_v[5];

    tick_sum = {1'b0, tick_count} + 17'd1;

    for (int i = 0; i < ccfe_pkg::FIELD_COUNT; i++) begin
      fields_next[i] = fields[i];
    end
    edit_mode_next   = edit_mode;
    field_index_next = field_index;
    blink_flag_next  = blink_flag;
    tick_count_next  = tick_count;
    commit_next      = 1'b0;

    case (ccfe_pkg::op_t'(op_q))
      ccfe_pkg::OP_TICK: begin
        if (tick_sum >= {1'b0, blink_period}) begin
          tick_count_next = 16'd0;
          blink_flag_next = !blink_flag;
        end else begin
          tick_count_next = tick_sum[15:0];
        end
      end
      ccfe_pkg::OP_MODE: begin
        if (!edit_mode) begin
          edit_mode_next   = 1'b1;
          field_index_next = 3'd0;
        end else begin
          edit_mode_next = 1'b0;
          commit_next    = 1'b1;
        end
      end
      ccfe_pkg::OP_SELECT: begin
        if (edit_mode) begin
          field_index_next = (field_index == ccfe_pkg::LAST_FIELD) ? 3'd0
                                                                   : field_index + 3'd1;
        end
      end
      ccfe_pkg::OP_UP: begin
        if (edit_mode) begin
          fields_next[0] = u_year[6:0];
          fields_next[1] = u_month[6:0];
          fields_next[2] = u_day[6:0];
          fields_next[3] = u_hour[6:0];
          fields_next[4] = u_minute[6:0];
          fields_next[5] = u_second[6:0];
        end
      end
      ccfe_pkg::OP_DOWN: begin
        if (edit_mode) begin
          fields_next[0] = d_year;
          fields_next[1] = d_month;
          fields_next[2] = d_day;
          fields_next[3] = d_hour;
          fields_next[4] = d_minute;
          fields_next[5] = d_second;
        end
      end
      ccfe_pkg::OP_LOAD: begin
        if (!edit_mode) begin
          fields_next[0] = ld_year_q;
          fields_next[1] = {3'd0, ld_month_q};
          fields_next[2] = {2'd0, ld_day_q};
          fields_next[3] = {2'd0, ld_hour_q};
          fields_next[4] = {1'b0, ld_minute_q};
          fields_next[5] = {1'b0, ld_second_q};
        end
      end
      default: begin
        // Unused operation codes leave the state as it is.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ccfe_pkg::FIELD_COUNT; i++) begin
        fields[i] <= 7'd0;
      end
      edit_mode   <= 1'b0;
      field_index <= 3'd0;
      blink_flag  <= 1'b0;
      tick_count  <= 16'd0;
    end else if (advance) begin
      for (int i = 0; i < ccfe_pkg::FIELD_COUNT; i++) begin
        fields[i] <= fields_next[i];
      end
      edit_mode   <= edit_mode_next;
      field_index <= field_index_next;
      blink_flag  <= blink_flag_next;
      tick_count  <= tick_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      year           <= fields_next[0];
      month          <= fields_next[1][3:0];
      day            <= fields_next[2][4:0];
      hour           <= fields_next[3][4:0];
      minute         <= fields_next[4][5:0];
      second         <= fields_next[5][5:0];
      editing        <= edit_mode_next;
      selected       <= field_index_next;
      blank_selected <= edit_mode_next && blink_flag_next;
      commit         <= commit_next;
    end
  end

endmodule

@@ tb/sv/clock_calendar_field_editor_test.sv @@
// ----------------------------------------------------------------------------
// Testbench for the calendar clock field editor
// Sends ticks, key presses and time loads on the input channel. A predictor
// inside the bench works out the readout that each accepted word must
// produce. Every readout is checked field by field, in order, against those
// predictions. The blink period is changed between phases while the editor
// is idle. Random stalls fall on both channels, and one long receiver
// hold-off fills the editor.
// ----------------------------------------------------------------------------
module clock_calendar_field_editor_test;

  // The two operation codes that the package leaves unused; the editor must
  // ignore them and simply report its state.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Positions of the fields in the calendar store.
  localparam int YEAR_IDX   = 0;
  localparam int MONTH_IDX  = 1;
  localparam int DAY_IDX    = 2;
  localparam int HOUR_IDX   = 3;
  localparam int MINUTE_IDX = 4;
  localparam int SECOND_IDX = 5;

  localparam logic [1:0] BLINK_PERIOD_ADDR = 2'd0;
  localparam int         CYCLE_LIMIT       = 300000;
  localparam int         REPORT_LIMIT      = 10;
  localparam int         HOLD_CYCLES       = 60;

  typedef struct {
    logic [2:0] op;
    logic [6:0] yr;
    logic [3:0] mon;
    logic [4:0] dy;
    logic [4:0] hr;
    logic [5:0] mins;
    logic [5:0] secs;
  } key_word_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       editing;
    logic [2:0] selected;
    logic       blank_selected;
    logic       commit;
  } readout_t;

  // Every input of the editor starts at a known value.
  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [2:0]  operation      = '0;
  logic [6:0]  load_year      = '0;
  logic [3:0]  load_month     = '0;
  logic [4:0]  load_day       = '0;
  logic [4:0]  load_hour      = '0;
  logic [5:0]  load_minute    = '0;
  logic [5:0]  load_second    = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [6:0]  year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        editing;
  logic [2:0]  selected;
  logic        blank_selected;
  logic        commit;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [1:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  clock_calendar_field_editor u_top (.*);

  always #1 clk = ~clk;

  // Words waiting to be offered, and the readouts predicted for words that
  // the editor has already taken.
  key_word_t queued_words[$];
  readout_t  expected_readouts[$];

  // Mirror of the editor state, advanced once per accepted word.
  logic [6:0]  cal_field[6];
  logic        edit_on;
  logic [2:0]  field_sel;
  logic        blink_on;
  logic [15:0] tick_total;
  logic [15:0] blink_ticks;

  // Stimulus-side view of the edit mode, known ahead of time because only
  // the mode key changes it.
  bit gen_editing;
  // Set in the final phase: neither side idles any more.
  bit calm;
  // Each increment asks the receiver for one long hold-off.
  int hold_asks;

  bit in_fire;
  int cycle_count;
  int faults;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  function automatic int month_length(int mon, int yr);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return (yr % 4 == 0) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Steps the selected field by one and then applies the wrap rules to every
  // field. A month outside one to twelve gives no day limit, so the day is
  // then left to run freely in its 7-bit store.
  function automatic void step_selected(bit up);
    int t[6];
    int lim;
    for (int i = 0; i < 6; i++) t[i] = cal_field[i];
    t[field_sel] += up ? 1 : -1;
    if (up) begin
      if (t[YEAR_IDX] > 99) t[YEAR_IDX] = 0;
      if (t[MONTH_IDX] > 12) t[MONTH_IDX] = 1;
      lim = month_length(t[MONTH_IDX], t[YEAR_IDX]);
      if (lim != 0 && t[DAY_IDX] > lim) t[DAY_IDX] = 1;
      if (t[HOUR_IDX] > 23) t[HOUR_IDX] = 0;
      if (t[MINUTE_IDX] > 59) t[MINUTE_IDX] = 0;
      if (t[SECOND_IDX] > 59) t[SECOND_IDX] = 0;
    end else begin
      // On the way down the year has no upper bound.
      if (t[YEAR_IDX] < 0) t[YEAR_IDX] = 99;
      if (t[MONTH_IDX] < 1) t[MONTH_IDX] = 12;
      lim = month_length(t[MONTH_IDX], t[YEAR_IDX]);
      if (lim != 0) begin
        if (t[DAY_IDX] < 1) t[DAY_IDX] = lim;
        if (t[DAY_IDX] > lim) t[DAY_IDX] = 1;
      end
      if (t[HOUR_IDX] < 0) t[HOUR_IDX] = 23;
      if (t[MINUTE_IDX] < 0) t[MINUTE_IDX] = 59;
      if (t[SECOND_IDX] < 0) t[SECOND_IDX] = 59;
    end
    for (int i = 0; i < 6; i++) cal_field[i] = 7'(t[i]);
  endfunction

  // Applies one word to the mirrored state and returns the readout it makes.
  function automatic readout_t advance_editor(key_word_t w);
    readout_t r;
    logic [16:0] next_count;
    r.commit = 1'b0;
    case (w.op)
      ccfe_pkg::OP_TICK: begin
        // The count may sit above a freshly lowered period; the compare is
        // "at or above", and a period of zero toggles on every tick.
        next_count = {1'b0, tick_total} + 17'd1;
        if (next_count >= {1'b0, blink_ticks}) begin
          next_count = '0;
          blink_on   = ~blink_on;
        end
        tick_total = next_count[15:0];
      end
      ccfe_pkg::OP_MODE: begin
        if (!edit_on) begin
          edit_on   = 1'b1;
          field_sel = 3'(YEAR_IDX);
        end else begin
          edit_on  = 1'b0;
          r.commit = 1'b1;
        end
      end
      ccfe_pkg::OP_SELECT: begin
        if (edit_on)
          field_sel = (field_sel == ccfe_pkg::LAST_FIELD) ? 3'd0 : field_sel + 3'd1;
      end
      ccfe_pkg::OP_UP, ccfe_pkg::OP_DOWN: begin
        if (edit_on) step_selected(w.op == ccfe_pkg::OP_UP);
      end
      ccfe_pkg::OP_LOAD: begin
        // Values outside the calendar are kept as given.
        if (!edit_on) begin
          cal_field[YEAR_IDX]   = w.yr;
          cal_field[MONTH_IDX]  = 7'(w.mon);
          cal_field[DAY_IDX]    = 7'(w.dy);
          cal_field[HOUR_IDX]   = 7'(w.hr);
          cal_field[MINUTE_IDX] = 7'(w.mins);
          cal_field[SECOND_IDX] = 7'(w.secs);
        end
      end
      default: ;
    endcase
    r.year           = cal_field[YEAR_IDX];
    r.month          = cal_field[MONTH_IDX][3:0];
    r.day            = cal_field[DAY_IDX][4:0];
    r.hour           = cal_field[HOUR_IDX][4:0];
    r.minute         = cal_field[MINUTE_IDX][5:0];
    r.second         = cal_field[SECOND_IDX][5:0];
    r.editing        = edit_on;
    r.selected       = field_sel;
    r.blank_selected = edit_on & blink_on;
    return r;
  endfunction

  function automatic string readout_text(readout_t r);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d edit=%0b sel=%0d blank=%0b commit=%0b",
                     r.year, r.month, r.day, r.hour, r.minute, r.second,
                     r.editing, r.selected, r.blank_selected, r.commit);
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus generation
  // ------------------------------------------------------------------------

  // Any word other than a load still carries random time fields, which the
  // editor must ignore; this also toggles every bit of those fields.
  task automatic queue_key(logic [2:0] op);
    key_word_t w;
    w.op   = op;
    w.yr   = 7'($urandom);
    w.mon  = 4'($urandom);
    w.dy   = 5'($urandom);
    w.hr   = 5'($urandom);
    w.mins = 6'($urandom);
    w.secs = 6'($urandom);
    if (op == ccfe_pkg::OP_MODE) gen_editing = !gen_editing;
    queued_words.push_back(w);
  endtask

  task automatic queue_load(int yr, int mon, int dy, int hr, int mins, int secs);
    key_word_t w;
    w.op   = ccfe_pkg::OP_LOAD;
    w.yr   = 7'(yr);
    w.mon  = 4'(mon);
    w.dy   = 5'(dy);
    w.hr   = 5'(hr);
    w.mins = 6'(mins);
    w.secs = 6'(secs);
    queued_words.push_back(w);
  endtask

  // One full edit session: load a time, enter edit mode, walk over a few
  // fields stepping them up or down with ticks in between, then commit.
  task automatic queue_session();
    int segments;
    int runs;
    bit up;
    if (gen_editing) queue_key(ccfe_pkg::OP_MODE);
    if ($urandom_range(0, 4) == 0)
      queue_load($urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    else
      queue_load($urandom_range(0, 99), $urandom_range(1, 12), $urandom_range(1, 31),
                 $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    queue_key(ccfe_pkg::OP_MODE);
    segments = $urandom_range(1, 4);
    for (int s = 0; s < segments; s++) begin
      repeat ($urandom_range(0, 5)) queue_key(ccfe_pkg::OP_SELECT);
      runs = $urandom_range(1, 35);
      up   = $urandom_range(0, 1);
      for (int k = 0; k < runs; k++) begin
        queue_key(up ? ccfe_pkg::OP_UP : ccfe_pkg::OP_DOWN);
        if ($urandom_range(0, 3) == 0) queue_key(ccfe_pkg::OP_TICK);
        if ($urandom_range(0, 20) == 0) queue_key(ccfe_pkg::OP_LOAD);
      end
    end
    queue_key(ccfe_pkg::OP_MODE);
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 2) == 0) queue_key(ccfe_pkg::OP_TICK);
      else queue_key(3'($urandom_range(0, 7)));
    end
  endtask

  // ------------------------------------------------------------------------
  // Configuration and phase control
  // ------------------------------------------------------------------------

  // Checked at the rising edge, where the queue and the input valid are
  // stable, so a word popped by the driver cannot slip past unseen.
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_words.size() != 0 || in_valid || expected_readouts.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle; the register takes the
  // value at the rising edge of the access cycle.
  task automatic write_blink_period(logic [15:0] period);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= BLINK_PERIOD_ADDR;
    pwdata  <= {16'd0, period};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    blink_ticks = period;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] period, int words, bit squeeze, bit quiet);
    int target;
    wait_idle();
    write_blink_period(period);
    calm = quiet;
    if (squeeze) hold_asks++;
    target = queued_words.size() + words;
    while (queued_words.size() < target) begin
      if ($urandom_range(0, 9) < 7) queue_session();
      else queue_noise();
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) cal_field[i] = '0;
    edit_on     = 1'b0;
    field_sel   = '0;
    blink_on    = 1'b0;
    tick_total  = '0;
    blink_ticks = ccfe_pkg::BLINK_RESET;
    gen_editing = 1'b0;
    calm        = 1'b0;
    hold_asks   = 0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed opening, under the reset blink period.
    queue_load(99, 2, 29, 23, 59, 59);
    // Out-of-range load: every field at its all-ones pattern.
    queue_load(127, 15, 31, 31, 63, 63);
    queue_key(OP_SPARE_LO);
    queue_key(OP_SPARE_HI);
    // Keys that do nothing outside edit mode.
    queue_key(ccfe_pkg::OP_SELECT);
    queue_key(ccfe_pkg::OP_UP);
    queue_key(ccfe_pkg::OP_DOWN);
    queue_key(ccfe_pkg::OP_MODE);
    // A load while editing is ignored.
    queue_load(1, 1, 1, 1, 1, 1);
    // Year 127 stepped up wraps to zero and pulls every other field in range.
    queue_key(ccfe_pkg::OP_UP);
    queue_key(ccfe_pkg::OP_DOWN);
    queue_key(ccfe_pkg::OP_SELECT);
    // Month one stepped down becomes twelve.
    queue_key(ccfe_pkg::OP_DOWN);
    // Select walks round past the last field back to the year.
    repeat (5) queue_key(ccfe_pkg::OP_SELECT);
    queue_key(ccfe_pkg::OP_MODE);
    // Month zero: the day is not wrapped and runs past 31.
    queue_load(0, 0, 31, 0, 0, 0);
    queue_key(ccfe_pkg::OP_MODE);
    repeat (2) queue_key(ccfe_pkg::OP_SELECT);
    queue_key(ccfe_pkg::OP_UP);
    queue_key(ccfe_pkg::OP_DOWN);
    queue_key(ccfe_pkg::OP_MODE);

    run_phase(16'd1,      90, 1'b0, 1'b0);
    run_phase(16'd0,      50, 1'b0, 1'b0);
    run_phase(16'hFFFF,   30, 1'b0, 1'b0);
    run_phase(16'd4,      90, 1'b1, 1'b0);
    run_phase(16'd2,      70, 1'b0, 1'b0);
    run_phase(16'd3,      40, 1'b0, 1'b1);

    wait_idle();
    repeat (10) @(negedge clk);
    if (faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // Driver: offers the next queued word at the falling edge, holding it
  // steady until the editor takes it, with random gaps between words.
  // ------------------------------------------------------------------------
  int        send_gap;
  key_word_t offered;

  always @(negedge clk) begin : feed
    logic next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
      send_gap   = 0;
    end else if (!in_valid || in_fire) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (queued_words.size() != 0) begin
        offered    = queued_words.pop_front();
        next_valid = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
      end
    end
    in_valid    <= next_valid;
    operation   <= offered.op;
    load_year   <= offered.yr;
    load_month  <= offered.mon;
    load_day    <= offered.dy;
    load_hour   <= offered.hr;
    load_minute <= offered.mins;
    load_second <= offered.secs;
  end

  // ------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off counted here while
  // the driver keeps offering words, so that the editor fills and stalls.
  // ------------------------------------------------------------------------
  int hold_served;
  int hold_left;
  int stall_left;

  always @(negedge clk) begin : drain
    logic next_ready;
    next_ready = 1'b1;
    if (rst) begin
      hold_served = 0;
      hold_left   = 0;
      stall_left  = 0;
    end else begin
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        next_ready = 1'b0;
      end
    end
    out_ready <= next_ready;
  end

  // ------------------------------------------------------------------------
  // Monitor: at each rising edge it checks a readout that is taken against
  // the oldest prediction, then predicts for a word that is taken.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : check
    readout_t  got;
    readout_t  want;
    key_word_t w;
    string     diff;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      in_fire = !rst && in_valid && in_ready;
      if (!rst && out_valid && out_ready) begin
        got = '{year, month, day, hour, minute, second,
                editing, selected, blank_selected, commit};
        if (expected_readouts.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("cycle %0d: readout with no word outstanding: %s",
                     cycle_count, readout_text(got));
        end else begin
          want = expected_readouts.pop_front();
          diff = "";
          if (got.year !== want.year) diff = {diff, " year"};
          if (got.month !== want.month) diff = {diff, " month"};
          if (got.day !== want.day) diff = {diff, " day"};
          if (got.hour !== want.hour) diff = {diff, " hour"};
          if (got.minute !== want.minute) diff = {diff, " minute"};
          if (got.second !== want.second) diff = {diff, " second"};
          if (got.editing !== want.editing) diff = {diff, " editing"};
          if (got.selected !== want.selected) diff = {diff, " selected"};
          if (got.blank_selected !== want.blank_selected) diff = {diff, " blank_selected"};
          if (got.commit !== want.commit) diff = {diff, " commit"};
          if (diff != "") begin
            faults++;
            if (faults <= REPORT_LIMIT)
              $display("cycle %0d: mismatch in%s\n  expected %s\n  actual   %s",
                       cycle_count, diff, readout_text(want), readout_text(got));
          end
        end
      end
      if (in_fire) begin
        w.op   = operation;
        w.yr   = load_year;
        w.mon  = load_month;
        w.dy   = load_day;
        w.hr   = load_hour;
        w.mins = load_minute;
        w.secs = load_second;
        expected_readouts.push_back(advance_editor(w));
      end
    end
  end

endmodule

@@ files.f @@
hdl/ccfe_pkg.sv
hdl/clock_calendar_field_editor.sv
tb/sv/clock_calendar_field_editor_test.sv
